// ===== rtl/epbi_pkg.sv =====
// Shared types and constants of the exact palette builder and indexer.
// Used by every module of the block; depends on nothing.
package epbi_pkg;

    // Request codes carried in the low bits of the input tuser.
    localparam logic [1:0] REQ_SCAN = 2'd0;
    localparam logic [1:0] REQ_MAP  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam int DEF_PALETTE_MAX = 255;
    localparam int DEF_COLOR_BITS  = 16;

    // Fixed field widths of the stream items.
    localparam int PIX_BITS = 16;
    localparam int IDX_BITS = 8;

    // Control part of the probe that ripples down the cell chain.
    typedef struct packed {
        logic                valid;
        logic [1:0]          req;
        logic [IDX_BITS-1:0] slot;
        logic                found;
        logic [IDX_BITS-1:0] idx;
    } probe_t;

endpackage

// ===== rtl/epbi_cell.sv =====
// One palette cell: holds the color at one palette index and checks the
// passing probe against it. Depends on epbi_pkg.
module epbi_cell #(
    parameter int IDX        = 0,
    parameter int COLOR_BITS = epbi_pkg::DEF_COLOR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [epbi_pkg::IDX_BITS-1:0]  count,
    input  logic                           shift_en,
    input  logic [COLOR_BITS-1:0]          shift_color,
    output logic [COLOR_BITS-1:0]          stored_color,
    input  epbi_pkg::probe_t               probe_in,
    input  logic [COLOR_BITS-1:0]          probe_color_in,
    input  logic [COLOR_BITS-1:0]          probe_pcol_in,
    output epbi_pkg::probe_t               probe_out,
    output logic [COLOR_BITS-1:0]          probe_color_out,
    output logic [COLOR_BITS-1:0]          probe_pcol_out
);
    import epbi_pkg::*;

    localparam logic [IDX_BITS-1:0] POS = IDX_BITS'(IDX);

    logic [COLOR_BITS-1:0] color_reg;
    probe_t                probe_reg;
    probe_t                probe_next;
    logic [COLOR_BITS-1:0] pcol_reg;
    logic [COLOR_BITS-1:0] pcol_next;
    logic [COLOR_BITS-1:0] pcolor_reg;
    logic                  live;
    logic                  hit_color;
    logic                  hit_slot;

    // Entries at or beyond the count hold stale colors and never match.
    assign live      = probe_in.valid && (POS < count);
    assign hit_color = live && (probe_in.req == REQ_SCAN || probe_in.req == REQ_MAP)
                       && (color_reg == probe_color_in);
    assign hit_slot  = live && (probe_in.req == REQ_READ) && (probe_in.slot == POS);

    always_comb
    begin
        probe_next = probe_in;
        pcol_next  = probe_pcol_in;
        if (hit_color)
        begin
            probe_next.found = 1'b1;
            probe_next.idx   = POS;
        end
        if (hit_slot)
        begin
            probe_next.found = 1'b1;
            probe_next.idx   = probe_in.slot;
            pcol_next        = color_reg;
        end
    end

    // Inserting a color pushes every entry one index up the chain.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            color_reg <= shift_color;
        end
        pcol_reg   <= pcol_next;
        pcolor_reg <= probe_color_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign stored_color    = color_reg;
    assign probe_out       = probe_reg;
    assign probe_color_out = pcolor_reg;
    assign probe_pcol_out  = pcol_reg;

endmodule

// ===== rtl/epbi_ctrl.sv =====
// Control of the palette chain: takes items, launches probes, applies scan
// updates from the chain tail and holds the result registers.
// Depends on epbi_pkg.
module epbi_ctrl #(
    parameter int PALETTE_MAX = epbi_pkg::DEF_PALETTE_MAX,
    parameter int COLOR_BITS  = epbi_pkg::DEF_COLOR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,
    output epbi_pkg::probe_t               launch,
    output logic [COLOR_BITS-1:0]          launch_color,
    output logic [COLOR_BITS-1:0]          launch_pcol,
    input  epbi_pkg::probe_t               tail,
    input  logic [COLOR_BITS-1:0]          tail_pcol,
    output logic [epbi_pkg::IDX_BITS-1:0]  count,
    output logic                           shift_en
);
    import epbi_pkg::*;

    localparam int WIDE = (COLOR_BITS > PIX_BITS) ? COLOR_BITS : PIX_BITS;
    localparam logic [IDX_BITS-1:0] MAXC = IDX_BITS'(PALETTE_MAX);

    logic                  busy_reg;
    logic [IDX_BITS-1:0]   count_reg;
    logic [IDX_BITS-1:0]   count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  launch_valid_reg;
    logic [1:0]            launch_req_reg;
    logic [IDX_BITS-1:0]   launch_slot_reg;
    logic [COLOR_BITS-1:0] lcolor_reg;

    logic                  pend_valid_reg;
    logic [IDX_BITS-1:0]   pend_idx_reg;
    logic                  pend_found_reg;
    logic [PIX_BITS-1:0]   pend_pcol_reg;
    logic [IDX_BITS-1:0]   pend_count_reg;
    logic                  pend_ovf_reg;

    logic                  out_valid_reg;
    logic [39:0]           out_data_reg;

    logic                  accept;
    logic                  move_out;
    logic                  res_found;
    logic [IDX_BITS-1:0]   res_idx;
    logic [WIDE-1:0]       pix_wide;
    logic [WIDE-1:0]       pcol_wide;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign move_out = pend_valid_reg && (!out_valid_reg || m_tready);

    assign pix_wide  = WIDE'(s_tdata[PIX_BITS-1:0]);
    assign pcol_wide = WIDE'(tail_pcol);

    // A scan that missed every held entry either appends or overflows.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        shift_en   = 1'b0;
        res_found  = tail.found;
        res_idx    = tail.idx;
        if (accept && s_tuser[1:0] == REQ_SCAN && s_tuser[2])
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (tail.valid && tail.req == REQ_SCAN && !tail.found)
        begin
            if (count_reg < MAXC)
            begin
                shift_en   = 1'b1;
                count_next = count_reg + 1'b1;
                res_found  = 1'b1;
                res_idx    = '0;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_req_reg  <= s_tuser[1:0];
            launch_slot_reg <= s_tdata[23:16];
            lcolor_reg      <= pix_wide[COLOR_BITS-1:0];
        end
        if (tail.valid)
        begin
            pend_idx_reg   <= res_idx;
            pend_found_reg <= res_found;
            pend_pcol_reg  <= pcol_wide[PIX_BITS-1:0];
            pend_count_reg <= count_next;
            pend_ovf_reg   <= ovf_next;
        end
        if (move_out)
        begin
            out_data_reg <= {6'd0, pend_ovf_reg, pend_count_reg, pend_pcol_reg,
                             pend_found_reg, pend_idx_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            launch_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            launch_valid_reg <= accept;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (move_out)
            begin
                busy_reg <= 1'b0;
            end
            if (tail.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        launch       = '0;
        launch.valid = launch_valid_reg;
        launch.req   = launch_req_reg;
        launch.slot  = launch_slot_reg;
    end

    assign launch_color = lcolor_reg;
    assign launch_pcol  = '0;
    assign count        = count_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("palette count beyond its maximum");

    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> !pend_valid_reg)
        else $error("chain tail result while a result is still pending");

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("probe left the chain while no item was in work");

    a_ovf_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(tail.valid && tail.req == REQ_SCAN && !tail.found))
        else $error("overflow set without a missed scan");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("item finished without a result in the output register");

endmodule

// ===== rtl/exact_palette_builder_indexer_top.sv =====
// Exact palette builder and indexer: a chain of palette cells and its control.
// Depends on epbi_pkg, epbi_cell and epbi_ctrl.
//
// After acceptance, an item's probe is registered at launch and then ripples
// through the chain of PALETTE_MAX cells one cell per cycle, each cell
// comparing its own color; the scan update is applied when the probe leaves
// the last cell, and the result passes through a pending register into the
// output register. A new item is accepted as soon as the previous result has
// moved to the output register, even while that result still waits to be
// taken, so only one item is in work in the chain at a time. Index 0 is the
// newest color: inserting a color shifts every held entry one cell along the
// chain. There is no clearing pass after reset; entries beyond the count are
// never consulted.
module exact_palette_builder_indexer_top #(
    parameter int PALETTE_MAX = epbi_pkg::DEF_PALETTE_MAX,
    parameter int COLOR_BITS  = epbi_pkg::DEF_COLOR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_color [15:0], palette_slot [23:16]
    input  logic [23:0] s_tdata,
    // req_type [1:0], first_of_image [2]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // color_index [7:0], found [8], palette_color [24:9], palette_count [32:25],
    // overflow [33], zero [39:34]
    output logic [39:0] m_tdata
);
    import epbi_pkg::*;

    probe_t                probe [PALETTE_MAX+1];
    logic [COLOR_BITS-1:0] pcolor [PALETTE_MAX+1];
    logic [COLOR_BITS-1:0] pcol [PALETTE_MAX+1];
    logic [COLOR_BITS-1:0] link [PALETTE_MAX+1];
    logic [IDX_BITS-1:0]   count;
    logic                  shift_en;

    // The color entering cell 0 on insertion is the one carried by the probe.
    assign link[0] = pcolor[PALETTE_MAX];

    epbi_ctrl #(
        .PALETTE_MAX (PALETTE_MAX),
        .COLOR_BITS  (COLOR_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .launch       (probe[0]),
        .launch_color (pcolor[0]),
        .launch_pcol  (pcol[0]),
        .tail         (probe[PALETTE_MAX]),
        .tail_pcol    (pcol[PALETTE_MAX]),
        .count        (count),
        .shift_en     (shift_en)
    );

    for (genvar i = 0; i < PALETTE_MAX; i++)
    begin : g_cell
        epbi_cell #(
            .IDX        (i),
            .COLOR_BITS (COLOR_BITS)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .count           (count),
            .shift_en        (shift_en),
            .shift_color     (link[i]),
            .stored_color    (link[i+1]),
            .probe_in        (probe[i]),
            .probe_color_in  (pcolor[i]),
            .probe_pcol_in   (pcol[i]),
            .probe_out       (probe[i+1]),
            .probe_color_out (pcolor[i+1]),
            .probe_pcol_out  (pcol[i+1])
        );
    end

endmodule
